// ===== hdl/tvt_pkg.sv =====
package tvt_pkg;

	localparam int CHANNEL_COUNT = 16;
	localparam logic [15:0] ENABLE_MASK_RESET = 16'hFFFF;
	localparam logic [6:0] VOLUME_MAX = 7'd64;

	localparam logic [3:0] EFF_TONE_PORTA = 4'd3;
	localparam logic [3:0] EFF_PORTA_VOLSLIDE = 4'd5;
	localparam logic [3:0] EFF_VIB_VOLSLIDE = 4'd6;
	localparam logic [3:0] EFF_TREMOLO = 4'd7;
	localparam logic [3:0] EFF_VOLSLIDE = 4'd10;
	localparam logic [3:0] EFF_SET_VOLUME = 4'd12;
	localparam logic [3:0] EFF_EXTENDED = 4'd14;

	localparam logic [3:0] EXT_TREMOLO_CTRL = 4'd7;
	localparam logic [3:0] EXT_FINE_UP = 4'd10;
	localparam logic [3:0] EXT_FINE_DOWN = 4'd11;
	localparam logic [3:0] EXT_CUT = 4'd12;
	localparam logic [3:0] EXT_NOTE_DELAY = 4'd13;

	localparam logic [1:0] WAVE_SINE = 2'd0;
	localparam logic [1:0] WAVE_RAMP = 2'd1;

	typedef struct packed {
		logic [3:0] channel_index;
		logic       tick_zero;
		logic [3:0] effect_code;
		logic [7:0] effect_parameter;
		logic [7:0] tick_counter;
		logic       has_instrument;
		logic [6:0] instrument_volume;
		logic       period_note;
		logic [7:0] vibrato_phase;
	} in_item_t;

	typedef struct packed {
		logic [3:0] result_channel;
		logic [6:0] tick_volume;
		logic [6:0] base_volume;
	} out_item_t;

	// decoded command handed from front to back
	typedef struct packed {
		logic [3:0] channel;
		logic       load_ins;
		logic [6:0] ins_vol;
		logic       set_vol;
		logic [6:0] set_val;
		logic       slide;
		logic       fine_up;
		logic       fine_down;
		logic       cut;
		logic       ctrl_wr;
		logic       phase_reset;
		logic       tremolo;
		logic [3:0] hi;
		logic [3:0] lo;
		logic       vib_flip;
	} cmd_t;

	function automatic logic [6:0] clamp_volume(input logic [7:0] v);
		clamp_volume = (v > 8'(VOLUME_MAX)) ? VOLUME_MAX : v[6:0];
	endfunction

	function automatic logic [7:0] sine_value(input logic [4:0] idx);
		case (idx)
			5'd0: sine_value = 8'd0;
			5'd1: sine_value = 8'd24;
			5'd2: sine_value = 8'd49;
			5'd3: sine_value = 8'd74;
			5'd4: sine_value = 8'd97;
			5'd5: sine_value = 8'd120;
			5'd6: sine_value = 8'd141;
			5'd7: sine_value = 8'd161;
			5'd8: sine_value = 8'd180;
			5'd9: sine_value = 8'd197;
			5'd10: sine_value = 8'd212;
			5'd11: sine_value = 8'd224;
			5'd12: sine_value = 8'd235;
			5'd13: sine_value = 8'd244;
			5'd14: sine_value = 8'd250;
			5'd15: sine_value = 8'd253;
			5'd16: sine_value = 8'd255;
			5'd17: sine_value = 8'd253;
			5'd18: sine_value = 8'd250;
			5'd19: sine_value = 8'd244;
			5'd20: sine_value = 8'd235;
			5'd21: sine_value = 8'd224;
			5'd22: sine_value = 8'd212;
			5'd23: sine_value = 8'd197;
			5'd24: sine_value = 8'd180;
			5'd25: sine_value = 8'd161;
			5'd26: sine_value = 8'd141;
			5'd27: sine_value = 8'd120;
			5'd28: sine_value = 8'd97;
			5'd29: sine_value = 8'd74;
			5'd30: sine_value = 8'd49;
			5'd31: sine_value = 8'd24;
			default: sine_value = 8'd0;
		endcase
	endfunction

endpackage

// ===== hdl/tvt_front.sv =====
module tvt_front #(
	parameter int CHANNEL_COUNT = tvt_pkg::CHANNEL_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  tvt_pkg::in_item_t in_item,
	output logic              push,
	output tvt_pkg::cmd_t     push_cmd
);

	localparam logic [4:0] CH_LIMIT = 5'(CHANNEL_COUNT);

	logic [15:0] enable_mask_q;
	logic [3:0]  eff;
	logic [3:0]  hi;
	logic [3:0]  lo;
	logic        t0;
	logic        is_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= tvt_pkg::ENABLE_MASK_RESET;
		end else if (cfg_valid) begin
			enable_mask_q <= cfg_data;
		end
	end

	assign eff = in_item.effect_code;
	assign hi = in_item.effect_parameter[7:4];
	assign lo = in_item.effect_parameter[3:0];
	assign t0 = in_item.tick_zero;
	assign is_ext = (eff == tvt_pkg::EFF_EXTENDED);

	// disabled or out-of-range channels are dropped here
	assign push = in_valid && !in_stall && enable_mask_q[in_item.channel_index]
		&& ({1'b0, in_item.channel_index} < CH_LIMIT);

	always_comb begin
		push_cmd.channel = in_item.channel_index;
		push_cmd.load_ins = t0 && in_item.has_instrument;
		push_cmd.ins_vol = tvt_pkg::clamp_volume({1'b0, in_item.instrument_volume});
		push_cmd.set_vol = t0 && (eff == tvt_pkg::EFF_SET_VOLUME);
		push_cmd.set_val = tvt_pkg::clamp_volume(in_item.effect_parameter);
		push_cmd.slide = !t0 && (eff inside {tvt_pkg::EFF_VOLSLIDE,
			tvt_pkg::EFF_PORTA_VOLSLIDE, tvt_pkg::EFF_VIB_VOLSLIDE});
		push_cmd.fine_up = is_ext && (hi == tvt_pkg::EXT_FINE_UP)
			&& (in_item.tick_counter == 8'd0);
		push_cmd.fine_down = is_ext && (hi == tvt_pkg::EXT_FINE_DOWN)
			&& (in_item.tick_counter == 8'd0);
		push_cmd.cut = is_ext && (hi == tvt_pkg::EXT_CUT)
			&& (in_item.tick_counter == {4'd0, lo});
		push_cmd.ctrl_wr = is_ext && (hi == tvt_pkg::EXT_TREMOLO_CTRL);
		push_cmd.phase_reset = t0 && in_item.period_note
			&& !(eff inside {tvt_pkg::EFF_TONE_PORTA, tvt_pkg::EFF_PORTA_VOLSLIDE})
			&& !(is_ext && (hi == tvt_pkg::EXT_NOTE_DELAY));
		push_cmd.tremolo = !t0 && (eff == tvt_pkg::EFF_TREMOLO);
		push_cmd.hi = hi;
		push_cmd.lo = lo;
		push_cmd.vib_flip = in_item.vibrato_phase[7];
	end

endmodule

// ===== hdl/tvt_queue.sv =====
module tvt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tvt_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          head_valid,
	output tvt_pkg::cmd_t head_cmd,
	input  logic          pop
);

	tvt_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/tvt_back.sv =====
module tvt_back #(
	parameter int CHANNEL_COUNT = tvt_pkg::CHANNEL_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  tvt_pkg::cmd_t      head_cmd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output tvt_pkg::out_item_t out_item
);

	localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	logic [6:0] chan_vol_q   [CHANNEL_COUNT];
	logic [7:0] trem_phase_q [CHANNEL_COUNT];
	logic [7:0] trem_sd_q    [CHANNEL_COUNT];
	logic [3:0] trem_ctrl_q  [CHANNEL_COUNT];

	logic               out_valid_q;
	tvt_pkg::out_item_t out_item_q;

	logic [IDX_W-1:0] ch;
	logic [7:0]       phase;
	logic [3:0]       ctrl;
	logic [6:0]       vol_a;
	logic [6:0]       vol_b;
	logic [6:0]       vol_c;
	logic [7:0]       sd_new;
	logic [7:0]       phase_new;
	logic [4:0]       idx;
	logic [7:0]       wave;
	logic [11:0]      product;
	logic [5:0]       amt;
	logic [6:0]       out_vol;
	logic             clear_phase;

	assign ch = head_cmd.channel[IDX_W-1:0];
	assign phase = trem_phase_q[ch];
	assign ctrl = trem_ctrl_q[ch];
	assign pop = head_valid && (!out_valid_q || !out_stall);
	assign clear_phase = head_cmd.phase_reset && !ctrl[2];

	// volume update: load / set / slide, then extended effects
	always_comb begin
		vol_a = chan_vol_q[ch];
		if (head_cmd.load_ins) begin
			vol_a = head_cmd.ins_vol;
		end
		if (head_cmd.set_vol) begin
			vol_a = head_cmd.set_val;
		end

		vol_b = vol_a;
		if (head_cmd.slide) begin
			if (head_cmd.hi != 4'd0) begin
				vol_b = tvt_pkg::clamp_volume({1'b0, vol_a} + {4'd0, head_cmd.hi});
			end else begin
				vol_b = (vol_a < {3'd0, head_cmd.lo}) ? 7'd0 : vol_a - {3'd0, head_cmd.lo};
			end
		end

		vol_c = vol_b;
		if (head_cmd.fine_up) begin
			vol_c = tvt_pkg::clamp_volume({1'b0, vol_b} + {4'd0, head_cmd.lo});
		end else if (head_cmd.fine_down) begin
			vol_c = (vol_b < {3'd0, head_cmd.lo}) ? 7'd0 : vol_b - {3'd0, head_cmd.lo};
		end else if (head_cmd.cut) begin
			vol_c = 7'd0;
		end
	end

	// tremolo
	always_comb begin
		sd_new = trem_sd_q[ch];
		if (head_cmd.lo != 4'd0) begin
			sd_new[3:0] = head_cmd.lo;
		end
		if (head_cmd.hi != 4'd0) begin
			sd_new[7:4] = head_cmd.hi;
		end
		idx = phase[6:2];
		case (ctrl[1:0])
			tvt_pkg::WAVE_SINE: wave = tvt_pkg::sine_value(idx);
			tvt_pkg::WAVE_RAMP: wave = head_cmd.vib_flip ? ~{idx, 3'b000} : {idx, 3'b000};
			default: wave = 8'd255;
		endcase
		product = {4'd0, wave} * {8'd0, sd_new[3:0]};
		amt = product[11:6];
		phase_new = phase + {sd_new[7:4], 2'b00};
		if (!head_cmd.tremolo) begin
			out_vol = vol_c;
		end else if (phase[7]) begin
			out_vol = (vol_c < {1'b0, amt}) ? 7'd0 : vol_c - {1'b0, amt};
		end else begin
			out_vol = tvt_pkg::clamp_volume({1'b0, vol_c} + {2'd0, amt});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				chan_vol_q[i] <= 7'd0;
				trem_phase_q[i] <= 8'd0;
				trem_sd_q[i] <= 8'd0;
				trem_ctrl_q[i] <= 4'd0;
			end
		end else if (pop) begin
			chan_vol_q[ch] <= vol_c;
			if (head_cmd.tremolo) begin
				trem_phase_q[ch] <= phase_new;
				trem_sd_q[ch] <= sd_new;
			end else if (clear_phase) begin
				trem_phase_q[ch] <= 8'd0;
			end
			if (head_cmd.ctrl_wr) begin
				trem_ctrl_q[ch] <= head_cmd.lo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q.result_channel <= head_cmd.channel;
			out_item_q.tick_volume <= out_vol;
			out_item_q.base_volume <= vol_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

// ===== hdl/tracker_volume_tremolo_unit.sv =====
// channel  | handshake           | beat
// ---------+---------------------+--------------------------------------
// cfg      | cfg_valid/cfg_ready | cfg_data: channel enable mask
// in       | in_valid/in_stall   | in_item: one channel tick
// out      | out_valid/out_stall | out_item: channel, output and base volume
//
// one beat per cycle sustained while out_stall is low; a result passes the queue
// and the back's output register (front decode into a two-entry queue, back
// updates channel state and registers); pops write channel state back, so ticks
// of the same channel may follow each other directly; reset clears all channel
// state at once and needs no sweep; in_stall rises only when the queue is full
module tracker_volume_tremolo_unit #(
	parameter int CHANNEL_COUNT = tvt_pkg::CHANNEL_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  tvt_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output tvt_pkg::out_item_t out_item
);

	logic          push;
	tvt_pkg::cmd_t push_cmd;
	logic          head_valid;
	tvt_pkg::cmd_t head_cmd;
	logic          pop;

	assign cfg_ready = 1'b1;

	tvt_front #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.push     (push),
		.push_cmd (push_cmd)
	);

	tvt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (in_stall),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop)
	);

	tvt_back #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
